// ===== sv/rcfr_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfr_pkg
// Shared types and constants for the serial RC frame receiver: frame layout,
// result status codes, register indexes and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rcfr_pkg;

  localparam logic [7:0]  HDR0       = 8'h20;
  localparam logic [7:0]  HDR1       = 8'h40;
  localparam logic [15:0] SUM_RESET  = 16'hFFFF;
  localparam logic [15:0] SUM_START  = 16'hFFFF - 16'h0020 - 16'h0040;
  localparam logic [4:0]  POS_BODY   = 5'd2;
  localparam logic [4:0]  POS_CHK_LO = 5'd30;
  localparam logic [4:0]  POS_CHK_HI = 5'd31;
  localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
  localparam int          SCALE_LIMIT = 500;

  localparam int IDX_W    = 4;
  localparam int CFG_IW   = 2;
  localparam int CFG_DW   = 16;

  localparam logic [CFG_IW-1:0] CFG_CENTER   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_DEADBAND = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_FAILSAFE = 2'd2;

  typedef enum logic [1:0] {
    ST_CHANNEL = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_TIMEOUT = 2'd2
  } rcfr_status_t;

  typedef struct packed {
    logic hdr_start;
    logic body_byte;
    logic tmo;
    logic final_bad;
    logic final_good;
    logic emit;
  } rcfr_cmd_t;

  typedef struct packed {
    logic is_hdr0;
    logic is_hdr1;
    logic pos_final;
    logic sum_ok;
    logic emit_last;
    logic out_busy;
  } rcfr_stat_t;

endpackage

// ===== sv/rcfr_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcfr_ctrl
// Frame controller: header hunt, body tracking and channel emission
// sequencing. Issues commands to the datapath from its status flags.
// ----------------------------------------------------------------------------
module rcfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_timeout,
  output logic               in_stall,
  input  logic               out_stall,
  input  rcfr_pkg::rcfr_stat_t stat,
  output rcfr_pkg::rcfr_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_H0   = 4'b0001,
    S_H1   = 4'b0010,
    S_BODY = 4'b0100,
    S_EMIT = 4'b1000
  } ctrl_state_t;

  ctrl_state_t state_r, state_nxt;
  logic        out_free;
  logic        acc;

  assign out_free = !stat.out_busy || !out_stall;
  assign in_stall = (state_r == S_EMIT) || !out_free;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    if (acc && in_timeout) begin
      cmd.tmo   = 1'b1;
      state_nxt = S_H0;
    end else begin
      unique case (state_r)
        S_H0: begin
          if (acc && stat.is_hdr0) state_nxt = S_H1;
        end
        S_H1: begin
          if (acc) begin
            if (stat.is_hdr1) begin
              cmd.hdr_start = 1'b1;
              state_nxt     = S_BODY;
            end else if (!stat.is_hdr0) begin
              state_nxt = S_H0;
            end
          end
        end
        S_BODY: begin
          if (acc) begin
            if (!stat.pos_final) begin
              cmd.body_byte = 1'b1;
            end else if (stat.sum_ok) begin
              cmd.final_good = 1'b1;
              state_nxt      = S_EMIT;
            end else begin
              cmd.final_bad = 1'b1;
              state_nxt     = S_H0;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            cmd.emit = 1'b1;
            if (stat.emit_last) state_nxt = S_H0;
          end
        end
        default: state_nxt = S_H0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_H0;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> in_stall)
    else $error("input taken while channels are emitted");

  a_one_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.tmo, cmd.final_bad, cmd.final_good, cmd.emit, cmd.body_byte,
              cmd.hdr_start}))
    else $error("conflicting datapath commands");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.tmo || cmd.final_bad) |-> (!stat.out_busy || !out_stall))
    else $error("output register overwritten while held");

endmodule

// ===== sv/rcfr_dp.sv =====
// ----------------------------------------------------------------------------
// rcfr_dp
// Frame datapath: configuration registers, byte position, checksum, channel
// store, failure counter, channel scaling and the result register.
// ----------------------------------------------------------------------------
module rcfr_dp #(
  parameter int CHANNELS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        cfg_we,
  input  logic [rcfr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rcfr_pkg::CFG_DW-1:0] cfg_wdata,
  input  rcfr_pkg::rcfr_cmd_t         cmd,
  output rcfr_pkg::rcfr_stat_t        stat,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [rcfr_pkg::IDX_W-1:0]  out_channel_index,
  output logic [15:0]                 out_channel_raw,
  output logic signed [10:0]          out_channel_scaled,
  output logic                        out_last,
  output logic [15:0]                 out_failsafe_count,
  output logic                        out_failsafe_active
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
  localparam logic [rcfr_pkg::IDX_W-1:0] CH_COUNT = rcfr_pkg::IDX_W'(CHANNELS);
  localparam logic signed [17:0] LIM_X = 18'(rcfr_pkg::SCALE_LIMIT);

  logic [15:0] center_r;
  logic [8:0]  deadband_r;
  logic [7:0]  frames_r;

  logic [4:0]  byte_index_r, byte_index_nxt;
  logic [15:0] running_sum_r, running_sum_nxt;
  logic [7:0]  checksum_low_r, checksum_low_nxt;
  logic [15:0] failure_count_r, failure_count_nxt;
  logic [CH_W-1:0] emit_idx_r, emit_idx_nxt;
  logic        out_valid_r, out_valid_nxt;

  logic [7:0]  store_lo_r [CHANNELS];
  logic [7:0]  store_hi_r [CHANNELS];

  logic [1:0]  out_status_r;
  logic [rcfr_pkg::IDX_W-1:0] out_index_r;
  logic [15:0] out_raw_r;
  logic signed [10:0] out_scaled_r;
  logic        out_last_r;
  logic [15:0] out_count_r;
  logic        out_active_r;

  logic [rcfr_pkg::IDX_W-1:0] ch_full;
  logic        in_chan_area;
  logic        store_we;
  logic [15:0] count_inc;
  logic        load_status;
  logic [15:0] raw_sel;
  logic signed [16:0] diff;
  logic signed [17:0] diff_x, db_x, clamp_x;
  logic        in_deadband;
  logic signed [10:0] scaled;

  assign ch_full      = rcfr_pkg::IDX_W'(byte_index_r[4:1]) - rcfr_pkg::IDX_W'(1);
  assign in_chan_area = (byte_index_r >= rcfr_pkg::POS_BODY)
                     && (byte_index_r < rcfr_pkg::POS_CHK_LO)
                     && (ch_full < CH_COUNT);
  assign store_we     = cmd.body_byte && in_chan_area;
  assign count_inc    = (failure_count_r == rcfr_pkg::COUNT_MAX) ? failure_count_r
                                                                 : failure_count_r + 16'd1;
  assign load_status  = cmd.tmo || cmd.final_bad;

  assign stat.is_hdr0    = (in_rx_byte == rcfr_pkg::HDR0);
  assign stat.is_hdr1    = (in_rx_byte == rcfr_pkg::HDR1);
  assign stat.pos_final  = (byte_index_r == rcfr_pkg::POS_CHK_HI);
  assign stat.sum_ok     = ({in_rx_byte, checksum_low_r} == running_sum_r);
  assign stat.emit_last  = (emit_idx_r == CH_LAST);
  assign stat.out_busy   = out_valid_r;

  // Scale the selected channel: offset, deadband, clamp, double.
  always_comb begin
    raw_sel     = {store_hi_r[emit_idx_r], store_lo_r[emit_idx_r]};
    diff        = $signed({1'b0, raw_sel}) - $signed({1'b0, center_r});
    diff_x      = {diff[16], diff};
    db_x        = $signed({9'b0, deadband_r});
    in_deadband = ((diff_x + db_x) > 18'sd0) && (diff_x < db_x);
    if (diff_x > LIM_X) begin
      clamp_x = LIM_X;
    end else if (diff_x < -LIM_X) begin
      clamp_x = -LIM_X;
    end else begin
      clamp_x = diff_x;
    end
    scaled = in_deadband ? 11'sd0 : $signed({clamp_x[9:0], 1'b0});
  end

  always_comb begin
    byte_index_nxt    = byte_index_r;
    running_sum_nxt   = running_sum_r;
    checksum_low_nxt  = checksum_low_r;
    failure_count_nxt = failure_count_r;
    emit_idx_nxt      = emit_idx_r;
    out_valid_nxt     = out_valid_r && out_stall;
    if (cmd.hdr_start) begin
      byte_index_nxt  = rcfr_pkg::POS_BODY;
      running_sum_nxt = rcfr_pkg::SUM_START;
    end
    if (cmd.body_byte) begin
      if (byte_index_r < rcfr_pkg::POS_CHK_LO) begin
        running_sum_nxt = running_sum_r - {8'b0, in_rx_byte};
        byte_index_nxt  = byte_index_r + 5'd1;
      end else begin
        checksum_low_nxt = in_rx_byte;
        byte_index_nxt   = rcfr_pkg::POS_CHK_HI;
      end
    end
    if (load_status) begin
      failure_count_nxt = count_inc;
      byte_index_nxt    = '0;
      out_valid_nxt     = 1'b1;
    end
    if (cmd.final_good) begin
      failure_count_nxt = '0;
      byte_index_nxt    = '0;
      emit_idx_nxt      = '0;
    end
    if (cmd.emit) begin
      emit_idx_nxt  = emit_idx_r + CH_W'(1);
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r        <= 16'd1500;
      deadband_r      <= 9'd10;
      frames_r        <= 8'd10;
      byte_index_r    <= '0;
      running_sum_r   <= rcfr_pkg::SUM_RESET;
      checksum_low_r  <= '0;
      failure_count_r <= '0;
      emit_idx_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rcfr_pkg::CFG_CENTER)   center_r   <= cfg_wdata;
        if (cfg_index == rcfr_pkg::CFG_DEADBAND) deadband_r <= cfg_wdata[8:0];
        if (cfg_index == rcfr_pkg::CFG_FAILSAFE) frames_r   <= cfg_wdata[7:0];
      end
      byte_index_r    <= byte_index_nxt;
      running_sum_r   <= running_sum_nxt;
      checksum_low_r  <= checksum_low_nxt;
      failure_count_r <= failure_count_nxt;
      emit_idx_r      <= emit_idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  // Low byte write clears the high byte of the entry.
  always_ff @(posedge clk) begin
    if (store_we) begin
      if (!byte_index_r[0]) begin
        store_lo_r[ch_full[CH_W-1:0]] <= in_rx_byte;
        store_hi_r[ch_full[CH_W-1:0]] <= 8'h00;
      end else begin
        store_hi_r[ch_full[CH_W-1:0]] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_status) begin
      out_status_r <= cmd.tmo ? rcfr_pkg::ST_TIMEOUT : rcfr_pkg::ST_BAD_SUM;
      out_index_r  <= '0;
      out_raw_r    <= '0;
      out_scaled_r <= '0;
      out_last_r   <= 1'b1;
      out_count_r  <= count_inc;
      out_active_r <= (count_inc >= {8'b0, frames_r});
    end else if (cmd.emit) begin
      out_status_r <= rcfr_pkg::ST_CHANNEL;
      out_index_r  <= rcfr_pkg::IDX_W'(emit_idx_r);
      out_raw_r    <= raw_sel;
      out_scaled_r <= scaled;
      out_last_r   <= (emit_idx_r == CH_LAST);
      out_count_r  <= failure_count_r;
      out_active_r <= (failure_count_r >= {8'b0, frames_r});
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_channel_index   = out_index_r;
  assign out_channel_raw     = out_raw_r;
  assign out_channel_scaled  = out_scaled_r;
  assign out_last            = out_last_r;
  assign out_failsafe_count  = out_count_r;
  assign out_failsafe_active = out_active_r;

  a_good_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.final_good |=> (failure_count_r == 16'd0) && (emit_idx_r == '0))
    else $error("good frame did not clear failure count");

endmodule

// ===== sv/rc_serial_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// rc_serial_frame_receiver
// Serial RC frame receiver: header hunt, checksum check, channel scaling and
// failsafe counting, one received byte or timeout tick per request.
// ----------------------------------------------------------------------------
// Each request carries one received byte or a timeout tick. The final byte of
// a good frame starts a run in which the controller reads all CHANNELS
// entries of the channel store into the single output register, one entry per
// cycle while the sink does not stall, and no request is taken during that
// run. A timeout or checksum failure gives one result in the cycle after its
// request. Requests stall while the output register holds a result that the
// sink is stalling.
module rc_serial_frame_receiver #(
  parameter int CHANNELS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_rx_byte,
  input  logic                        in_timeout,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [rcfr_pkg::IDX_W-1:0]  out_channel_index,
  output logic [15:0]                 out_channel_raw,
  output logic signed [10:0]          out_channel_scaled,
  output logic                        out_last,
  output logic [15:0]                 out_failsafe_count,
  output logic                        out_failsafe_active,
  input  logic                        cfg_we,
  input  logic [rcfr_pkg::CFG_IW-1:0] cfg_index,
  input  logic [rcfr_pkg::CFG_DW-1:0] cfg_wdata
);

  rcfr_pkg::rcfr_cmd_t  cmd;
  rcfr_pkg::rcfr_stat_t stat;

  rcfr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_timeout (in_timeout),
    .in_stall   (in_stall),
    .out_stall  (out_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  rcfr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_rx_byte          (in_rx_byte),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .cmd                 (cmd),
    .stat                (stat),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_channel_index   (out_channel_index),
    .out_channel_raw     (out_channel_raw),
    .out_channel_scaled  (out_channel_scaled),
    .out_last            (out_last),
    .out_failsafe_count  (out_failsafe_count),
    .out_failsafe_active (out_failsafe_active)
  );

endmodule
